// ===== design/sdds_pkg.sv =====
// Shared types and constants of the diamond-difference sweep block.
package sdds_pkg;

   localparam int MAX_ROW_DEF   = 64;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int FRAC_BITS_DEF = 16;

   localparam int DATA_W    = 32;
   localparam int COEFF_W   = 31;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COEFF      = 3'd0,
      CSR_LINE_COEFF     = 3'd1,
      CSR_PLANE_COEFF    = 3'd2,
      CSR_ANGLE_WEIGHT   = 3'd3,
      CSR_CELLS_PER_ROW  = 3'd4,
      CSR_ROWS_PER_PLANE = 3'd5,
      CSR_PLANE_COUNT    = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_SUM,
      ST_CHECK,
      ST_DIV,
      ST_CSET,
      ST_WB,
      ST_WMUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  source;
      logic        [COEFF_W-1:0] sigma_total;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] cell_flux;
      logic signed [DATA_W-1:0] weighted_flux;
      logic                     end_of_sweep;
   } rsp_type;

endpackage

// ===== design/sn_diamond_difference_sweep.sv =====
// Diamond-difference sweep: one mesh cell per item, bit-serial multiply and divide.
//
// Usage: cells of one angle and group enter on the req_ channel in sweep order
// (along a row, then rows of a plane, then planes), each with its source and
// total cross section. Each item yields one rsp_ item: cell flux, weighted flux
// and an end-of-sweep mark on the last cell. Coefficients, weight and extents
// are written on the csr_ channel while the block is idle; csr_ready is high.
// Steps: after acceptance the block reads the line and plane stores, loads the
// operands and runs the shift-add multiplier on the three flux products in
// parallel, forms numerator and denominator, then runs the restoring divider
// (one quotient bit a cycle) unless the denominator is zero or the quotient
// saturates, and reuses the first multiplier lane for the weight product; the
// result then enters the output register. Row, line and plane fluxes live in a
// register, a line memory and a plane memory, read and written once per item.
// Reset clears the sweep position, the row flux and the configuration; the
// stores hold no valid data until the sweep writes them. A stalled receiver
// holds the result in the output register; the block still takes the next
// item and finishes its work, then waits until the register frees up.
module sn_diamond_difference_sweep
   import sdds_pkg::*;
#(
   parameter int MAX_ROW   = MAX_ROW_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   localparam int CI_W      = $clog2(MAX_ROW);
   localparam int RI_W      = $clog2(MAX_ROWS);
   localparam int PI_W      = $clog2(MAX_ROW * MAX_ROWS);
   localparam int EXT_W     = $clog2((MAX_ROW > MAX_ROWS ? MAX_ROW : MAX_ROWS) + 128) + 1;
   localparam int NUM_W     = 66 - FRAC_BITS;
   localparam int DVD_W     = NUM_W + FRAC_BITS;
   localparam int PROD_W    = 63;
   localparam int DEN_W     = 33;
   localparam int QUO_W     = 31;
   localparam int SAT_SHIFT = 31 - FRAC_BITS;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v,
                                                  input logic [EXT_W-1:0] hi);
      if (v == '0) return EXT_W'(1);
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   function automatic logic [PROD_W-1:0] mul_step(input logic [PROD_W-1:0]  acc,
                                                  input logic [COEFF_W-1:0] m,
                                                  input logic               b);
      logic [DATA_W-1:0] s;
      s = {1'b0, acc[PROD_W-1:DATA_W]} + {1'b0, (b ? m : '0)};
      return {s, acc[DATA_W-1:1]};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_diff(input logic signed [DATA_W-1:0] c,
                                                         input logic signed [DATA_W-1:0] x);
      logic signed [DATA_W+1:0] d;
      d = {c[DATA_W-1], c, 1'b0} - {{2{x[DATA_W-1]}}, x};
      if (d[DATA_W+1:DATA_W-1] == 3'b000 || d[DATA_W+1:DATA_W-1] == 3'b111) begin
         return d[DATA_W-1:0];
      end
      return d[DATA_W+1] ? S32_MIN : S32_MAX;
   endfunction

   state_type state_ff, state_in;

   logic [COEFF_W-1:0] row_coeff_ff, line_coeff_ff, plane_coeff_ff, angle_weight_ff;
   logic [6:0]         cells_cfg_ff, rows_cfg_ff;
   logic [15:0]        planes_cfg_ff;

   logic [CI_W-1:0] ci_ff, ci_in;
   logic [RI_W-1:0] ri_ff, ri_in;
   logic [15:0]     pl_ff, pl_in;
   logic [PI_W-1:0] pi_addr;
   logic [EXT_W-1:0] cells, rows;
   logic [16:0]      planes;
   logic             last_cell;

   logic signed [DATA_W-1:0] line_mem [MAX_ROW];
   logic signed [DATA_W-1:0] plane_mem [MAX_ROW * MAX_ROWS];
   logic signed [DATA_W-1:0] line_rd_ff, plane_rd_ff;

   logic signed [DATA_W-1:0]  src_ff;
   logic [COEFF_W-1:0]        sig_ff;
   logic signed [DATA_W-1:0]  row_flux_ff;
   logic signed [DATA_W-1:0]  in_row_ff, in_line_ff, in_plane_ff;
   logic signed [DATA_W-1:0]  in_row_sel, in_line_sel, in_plane_sel;

   logic [COEFF_W-1:0] mcand_ff [3];
   logic [DATA_W-1:0]  mplier_ff [3];
   logic [PROD_W-1:0]  acc_ff [3];
   logic [4:0]         cnt_ff;

   logic signed [NUM_W-1:0] num_in, num_ff;
   logic [NUM_W-1:0]        mag_ff;
   logic                    neg_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [DVD_W-1:0]        dvd_full;
   logic [QUO_W-1:0]        dvd_ff, q_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [DEN_W:0]          rem_sh;
   logic                    rem_ge;
   logic                    quo_sat;
   logic signed [DATA_W-1:0] c_ff;

   logic [PROD_W-1:0]        wprod;
   logic signed [DATA_W-1:0] weighted_in;

   logic    load_out;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // extents and position
   always_comb begin
      cells     = clamp_ext(EXT_W'(cells_cfg_ff), EXT_W'(MAX_ROW));
      rows      = clamp_ext(EXT_W'(rows_cfg_ff), EXT_W'(MAX_ROWS));
      planes    = (planes_cfg_ff == '0) ? 17'd1 : {1'b0, planes_cfg_ff};
      pi_addr   = PI_W'(ri_ff) * PI_W'(MAX_ROW) + PI_W'(ci_ff);
      last_cell = (EXT_W'(ci_ff) + EXT_W'(1) >= cells) &&
                  (EXT_W'(ri_ff) + EXT_W'(1) >= rows) &&
                  ({1'b0, pl_ff} + 17'd1 >= planes);
      ci_in = ci_ff;
      ri_in = ri_ff;
      pl_in = pl_ff;
      if (EXT_W'(ci_ff) + EXT_W'(1) >= cells) begin
         ci_in = '0;
         if (EXT_W'(ri_ff) + EXT_W'(1) >= rows) begin
            ri_in = '0;
            pl_in = ({1'b0, pl_ff} + 17'd1 >= planes) ? '0 : pl_ff + 16'd1;
         end else begin
            ri_in = ri_ff + RI_W'(1);
         end
      end else begin
         ci_in = ci_ff + CI_W'(1);
      end
   end

   // datapath combinational terms
   always_comb begin
      logic [NUM_W-1:0] t0, t1, t2;
      in_row_sel   = (ci_ff == '0) ? '0 : row_flux_ff;
      in_line_sel  = (ri_ff == '0) ? '0 : line_rd_ff;
      in_plane_sel = (pl_ff == '0) ? '0 : plane_rd_ff;
      t0 = NUM_W'(acc_ff[0] >> FRAC_BITS);
      t1 = NUM_W'(acc_ff[1] >> FRAC_BITS);
      t2 = NUM_W'(acc_ff[2] >> FRAC_BITS);
      num_in = (in_row_ff[DATA_W-1]   ? -$signed(t0) : $signed(t0)) +
               (in_line_ff[DATA_W-1]  ? -$signed(t1) : $signed(t1)) +
               (in_plane_ff[DATA_W-1] ? -$signed(t2) : $signed(t2)) +
               NUM_W'(src_ff);
      dvd_full = DVD_W'(mag_ff) << FRAC_BITS;
      quo_sat  = DVD_W'(mag_ff) >= (DVD_W'(den_ff) << SAT_SHIFT);
      rem_sh   = {rem_ff, dvd_ff[QUO_W-1]};
      rem_ge   = rem_sh >= {1'b0, den_ff};
      wprod    = acc_ff[0] >> FRAC_BITS;
      if (!c_ff[DATA_W-1]) begin
         weighted_in = (wprod > PROD_W'(32'h7FFF_FFFF)) ? S32_MAX : DATA_W'(wprod);
      end else begin
         weighted_in = (wprod > PROD_W'(32'h8000_0000)) ? S32_MIN : DATA_W'(-wprod);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_READ;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_MUL;
         ST_MUL:    if (cnt_ff == 5'd31) state_in = ST_SUM;
         ST_SUM:    state_in = ST_CHECK;
         ST_CHECK:  state_in = (den_ff == '0 || quo_sat) ? ST_WB : ST_DIV;
         ST_DIV:    if (cnt_ff == 5'd30) state_in = ST_CSET;
         ST_CSET:   state_in = ST_WB;
         ST_WB:     state_in = ST_WMUL;
         ST_WMUL:   if (cnt_ff == 5'd31) state_in = ST_FINISH;
         ST_FINISH: if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      load_out  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         row_coeff_ff    <= '0;
         line_coeff_ff   <= '0;
         plane_coeff_ff  <= '0;
         angle_weight_ff <= '0;
         cells_cfg_ff    <= 7'd1;
         rows_cfg_ff     <= 7'd1;
         planes_cfg_ff   <= 16'd1;
         ci_ff           <= '0;
         ri_ff           <= '0;
         pl_ff           <= '0;
         row_flux_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_ROW_COEFF:      row_coeff_ff    <= csr_data[COEFF_W-1:0];
               CSR_LINE_COEFF:     line_coeff_ff   <= csr_data[COEFF_W-1:0];
               CSR_PLANE_COEFF:    plane_coeff_ff  <= csr_data[COEFF_W-1:0];
               CSR_ANGLE_WEIGHT:   angle_weight_ff <= csr_data[COEFF_W-1:0];
               CSR_CELLS_PER_ROW:  cells_cfg_ff    <= csr_data[6:0];
               CSR_ROWS_PER_PLANE: rows_cfg_ff     <= csr_data[6:0];
               CSR_PLANE_COUNT:    planes_cfg_ff   <= csr_data[15:0];
               default: ;
            endcase
         end
         if (state_ff == ST_WB) begin
            row_flux_ff <= sat_diff(c_ff, in_row_ff);
         end
         if (load_out) begin
            ci_ff <= ci_in;
            ri_ff <= ri_in;
            pl_ff <= pl_in;
         end
      end
   end

   // line and plane stores
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         line_rd_ff  <= line_mem[ci_ff];
         plane_rd_ff <= plane_mem[pi_addr];
      end
      if (state_ff == ST_WB) begin
         line_mem[ci_ff]    <= sat_diff(c_ff, in_line_ff);
         plane_mem[pi_addr] <= sat_diff(c_ff, in_plane_ff);
      end
   end

   // serial datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               src_ff <= req_data.source;
               sig_ff <= req_data.sigma_total;
            end
         end
         ST_LOAD: begin
            in_row_ff    <= in_row_sel;
            in_line_ff   <= in_line_sel;
            in_plane_ff  <= in_plane_sel;
            mplier_ff[0] <= abs32(in_row_sel);
            mplier_ff[1] <= abs32(in_line_sel);
            mplier_ff[2] <= abs32(in_plane_sel);
            mcand_ff[0]  <= row_coeff_ff;
            mcand_ff[1]  <= line_coeff_ff;
            mcand_ff[2]  <= plane_coeff_ff;
            acc_ff[0]    <= '0;
            acc_ff[1]    <= '0;
            acc_ff[2]    <= '0;
            cnt_ff       <= '0;
         end
         ST_MUL: begin
            for (int k = 0; k < 3; k++) begin
               acc_ff[k]    <= mul_step(acc_ff[k], mcand_ff[k], mplier_ff[k][0]);
               mplier_ff[k] <= mplier_ff[k] >> 1;
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
         ST_SUM: begin
            num_ff <= num_in;
            mag_ff <= num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);
            neg_ff <= num_in[NUM_W-1];
            den_ff <= DEN_W'(sig_ff) + DEN_W'(row_coeff_ff) + DEN_W'(line_coeff_ff) +
                      DEN_W'(plane_coeff_ff);
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               c_ff <= (num_ff > 0) ? S32_MAX : ((num_ff < 0) ? S32_MIN : '0);
            end else if (quo_sat) begin
               c_ff <= neg_ff ? S32_MIN : S32_MAX;
            end
            rem_ff <= DEN_W'(dvd_full >> QUO_W);
            dvd_ff <= dvd_full[QUO_W-1:0];
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            q_ff   <= {q_ff[QUO_W-2:0], rem_ge};
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff + 5'd1;
         end
         ST_CSET: begin
            c_ff <= neg_ff ? DATA_W'(-{1'b0, q_ff}) : {1'b0, q_ff};
         end
         ST_WB: begin
            mplier_ff[0] <= abs32(c_ff);
            mcand_ff[0]  <= angle_weight_ff;
            acc_ff[0]    <= '0;
            cnt_ff       <= '0;
         end
         ST_WMUL: begin
            acc_ff[0]    <= mul_step(acc_ff[0], mcand_ff[0], mplier_ff[0][0]);
            mplier_ff[0] <= mplier_ff[0] >> 1;
            cnt_ff       <= cnt_ff + 5'd1;
         end
         ST_FINISH: begin
            if (load_out) begin
               rsp_data_ff.cell_flux     <= c_ff;
               rsp_data_ff.weighted_flux <= weighted_in;
               rsp_data_ff.end_of_sweep  <= last_cell;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== design/sdds_checker.sv =====
// Port-level checks of the sweep block, bound to its top level.
module sdds_checker
   import sdds_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sn_diamond_difference_sweep sdds_checker u_sdds_checker (.*);

// ===== test/sn_diamond_difference_sweep_tb.sv =====
// Self-checking testbench for the diamond-difference sweep block.
`timescale 1ns / 100ps

import sdds_pkg::*;

class flux_scoreboard;
   localparam int FB = FRAC_BITS_DEF;

   bit [COEFF_W-1:0] row_c, line_c, plane_c, weight;
   bit [6:0]         cells_r, rows_r;
   bit [15:0]        planes_r;

   int          row_flux;
   int          line_st[MAX_ROW_DEF];
   int          plane_st[MAX_ROW_DEF*MAX_ROWS_DEF];
   int unsigned cell_pos, row_pos, plane_pos;

   rsp_type expected_flux[$];
   int      errors;

   function new();
      row_c = 0; line_c = 0; plane_c = 0; weight = 0;
      cells_r = 1; rows_r = 1; planes_r = 1;
      row_flux = 0; cell_pos = 0; row_pos = 0; plane_pos = 0;
      errors = 0;
   endfunction

   function void configure(csr_index_type idx, logic [31:0] d);
      case (idx)
         CSR_ROW_COEFF:      row_c = d[30:0];
         CSR_LINE_COEFF:     line_c = d[30:0];
         CSR_PLANE_COEFF:    plane_c = d[30:0];
         CSR_ANGLE_WEIGHT:   weight = d[30:0];
         CSR_CELLS_PER_ROW:  cells_r = d[6:0];
         CSR_ROWS_PER_PLANE: rows_r = d[6:0];
         CSR_PLANE_COUNT:    planes_r = d[15:0];
         default: ;
      endcase
   endfunction

   function int sat32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return int'(x);
   endfunction

   function longint scale(longint unsigned coeff, longint v);
      longint unsigned mag, p;
      mag = (v < 0) ? longint'(-v) : v;
      p = (mag * coeff) >> FB;
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   function int quotient(longint num, longint unsigned den);
      bit neg;
      longint unsigned mag, q, r, res;
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      if (den == 0) begin
         if (num > 0) return 32'h7FFFFFFF;
         if (num < 0) return 32'h80000000;
         return 0;
      end
      q = mag / den;
      r = mag % den;
      if (q >= (64'd1 << (31 - FB)))
         return neg ? 32'h80000000 : 32'h7FFFFFFF;
      res = (q << FB) + ((r << FB) / den);
      return sat32(neg ? -longint'(res) : longint'(res));
   endfunction

   function int unsigned extent(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function void note(req_type r);
      int unsigned cells, rows, planes, ci, ri, pidx;
      longint in_row, in_line, in_plane, num, c2;
      longint unsigned den;
      int c;
      bit last;
      rsp_type e;
      cells = extent(cells_r, MAX_ROW_DEF);
      rows = extent(rows_r, MAX_ROWS_DEF);
      planes = (planes_r == 0) ? 1 : planes_r;
      ci = cell_pos % MAX_ROW_DEF;
      ri = row_pos % MAX_ROWS_DEF;
      pidx = ri * MAX_ROW_DEF + ci;
      in_row = (cell_pos == 0) ? 0 : row_flux;
      in_line = (row_pos == 0) ? 0 : line_st[ci];
      in_plane = (plane_pos == 0) ? 0 : plane_st[pidx];
      num = scale(row_c, in_row) + scale(line_c, in_line) + scale(plane_c, in_plane)
            + longint'(r.source);
      den = longint'(r.sigma_total) + row_c + line_c + plane_c;
      c = quotient(num, den);
      c2 = 2 * longint'(c);
      row_flux = sat32(c2 - in_row);
      line_st[ci] = sat32(c2 - in_line);
      plane_st[pidx] = sat32(c2 - in_plane);
      last = (cell_pos + 1 >= cells) && (row_pos + 1 >= rows) && (plane_pos + 1 >= planes);
      cell_pos++;
      if (cell_pos >= cells) begin
         cell_pos = 0;
         row_pos++;
         if (row_pos >= rows) begin
            row_pos = 0;
            plane_pos++;
            if (plane_pos >= planes) plane_pos = 0;
         end
      end
      e.cell_flux = c;
      e.weighted_flux = sat32(scale(weight, c));
      e.end_of_sweep = last;
      expected_flux.push_back(e);
   endfunction

   function void check(rsp_type a);
      rsp_type e;
      if (expected_flux.size() == 0) begin
         $error("result with no item pending: %h", a);
         errors++;
         return;
      end
      e = expected_flux.pop_front();
      if (a.cell_flux !== e.cell_flux) begin
         $error("cell_flux expected %h actual %h", e.cell_flux, a.cell_flux);
         errors++;
      end
      if (a.weighted_flux !== e.weighted_flux) begin
         $error("weighted_flux expected %h actual %h", e.weighted_flux, a.weighted_flux);
         errors++;
      end
      if (a.end_of_sweep !== e.end_of_sweep) begin
         $error("end_of_sweep expected %b actual %b", e.end_of_sweep, a.end_of_sweep);
         errors++;
      end
   endfunction
endclass

module sn_diamond_difference_sweep_tb;

   localparam int IDLE_LIMIT = 2000;
   localparam int ITEM_COUNT = 1250;
   localparam int DRAIN_WAIT = 110;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   rsp_type              rsp_data;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;

   flux_scoreboard sb = new();
   int  items_sent = 0;
   bit  calm = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;

   sn_diamond_difference_sweep u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_cell(logic signed [31:0] src, logic [30:0] sig);
      req_type r;
      r.source = src;
      r.sigma_total = sig;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(r);
      items_sent++;
      if (items_sent > ITEM_COUNT - 150) calm = 1;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_flux.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.configure(idx, d);
   endtask

   task automatic set_sweep(logic [31:0] rc, logic [31:0] lc, logic [31:0] pc,
                            logic [31:0] w, logic [31:0] cells, logic [31:0] rows,
                            logic [31:0] planes);
      write_reg(CSR_ROW_COEFF, rc);
      write_reg(CSR_LINE_COEFF, lc);
      write_reg(CSR_PLANE_COEFF, pc);
      write_reg(CSR_ANGLE_WEIGHT, w);
      write_reg(CSR_CELLS_PER_ROW, cells);
      write_reg(CSR_ROWS_PER_PLANE, rows);
      write_reg(CSR_PLANE_COUNT, planes);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom & 32'h7FFFFFFF;
         2: return 32'h7FFFFFFF;
         default: return $urandom_range(0, 32'h30000);
      endcase
   endfunction

   function automatic logic [31:0] pick_source();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
      endcase
   endfunction

   function automatic logic [30:0] pick_sigma();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return $urandom;
         default: return $urandom_range(0, 32'h40000);
      endcase
   endfunction

   function automatic int unsigned eff(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   initial begin
      int unsigned cells, rows, planes, n;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero denominator and extremes at reset configuration
      send_cell(32'h7FFFFFFF, 0);
      send_cell(32'h80000000, 0);
      send_cell(0, 0);
      send_cell(1, 31'h7FFFFFFF);
      send_cell(-32'sh10000, 31'h10000);
      send_cell(32'h7FFFFFFF, 1);
      drain();

      // full 2x2x2 sweep with saturating weight
      set_sweep(32'h10000, 32'h10000, 32'h10000, 32'h7FFFFFFF, 2, 2, 2);
      send_cell(32'h7FFFFFFF, 31'h7FFFFFFF);
      send_cell(32'h80000000, 0);
      send_cell(32'h30000, 31'h8000);
      send_cell(-32'sh50000, 31'h20000);
      send_cell(32'h7FFFFFFF, 0);
      send_cell(32'h12345, 31'h7FFFFFFF);
      send_cell(32'h80000000, 31'h1);
      send_cell(32'h40000, 31'h10000);
      drain();

      // long plane count, then shortened mid-sweep so the position wraps
      set_sweep(32'h7FFFFFFF, 0, 32'h8000, 32'h8000, 0, 0, 65535);
      repeat (5) send_cell(pick_source(), pick_sigma());
      drain();
      write_reg(CSR_PLANE_COUNT, 1);
      csr_valid <= 0;
      send_cell(pick_source(), pick_sigma());
      drain();

      while (items_sent < ITEM_COUNT) begin
         case ($urandom_range(0, 9))
            0: begin cells = ($urandom_range(0, 1)) ? 127 : 64; rows = 1;
               planes = $urandom_range(1, 2); end
            1: begin cells = $urandom_range(0, 1); rows = 64; planes = 1; end
            2: begin cells = 0; rows = 0; planes = $urandom_range(0, 4); end
            default: begin cells = $urandom_range(1, 8); rows = $urandom_range(1, 4);
               planes = $urandom_range(1, 3); end
         endcase
         set_sweep(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                   cells, rows, planes);
         n = eff(cells, MAX_ROW_DEF) * eff(rows, MAX_ROWS_DEF) * eff(planes, 65535)
             * $urandom_range(1, 3);
         repeat (n) send_cell(pick_source(), pick_sigma());
         drain();
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sn_diamond_difference_sweep.f =====
design/sdds_pkg.sv
design/sn_diamond_difference_sweep.sv
design/sdds_checker.sv
test/sn_diamond_difference_sweep_tb.sv
